### hw/rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU key-value cache.
// Used by the controller, the datapath and the top level; depends on nothing.

package lkvc_pkg;

    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;
    localparam int CAP_W      = 5;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_CAPACITY_ADDR = 2'd0;
    localparam logic [CAP_W-1:0]      CAPACITY_RESET    = 5'd16;
    localparam logic [DATA_W-1:0]     READ_MISS         = 32'hFFFF_FFFF;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } lkvc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
    } lkvc_cmd_t;

endpackage

### hw/rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
// Controller for the LRU key-value cache: sequences lookup and update, owns
// both handshakes and the result valid flag. Depends on lkvc_pkg.

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output lkvc_cmd_t cmd
);

    lkvc_state_t state_reg;
    lkvc_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.update  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_UPDATE: begin
                // The result register must be free or draining this cycle.
                cmd.update = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        if (cmd.update) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### hw/rtl/lkvc_datapath.sv
`timescale 1ns / 1ps
// Datapath for the LRU key-value cache: key compare array, value store,
// recency ranks, fill count and result register. Depends on lkvc_pkg.

module lkvc_datapath
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int FILL_W      = $clog2(MAX_ENTRIES + 1)
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lkvc_cmd_t                cmd,
    input  logic                     s_kind,
    input  logic signed [KEY_W-1:0]  s_key,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic [FILL_W-1:0]        eff_cap,
    output logic                     m_hit,
    output logic signed [DATA_W-1:0] m_read_value
);

    logic [KEY_W-1:0]  entry_key_reg   [MAX_ENTRIES];
    logic [DATA_W-1:0] entry_value_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]  rank_reg        [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [FILL_W-1:0] fill_count_reg;

    logic              kind_reg;
    logic              hit_reg;
    logic              insert_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [FILL_W-1:0] thresh_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] value_reg;
    logic              m_hit_reg;
    logic [DATA_W-1:0] m_read_value_reg;

    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] victim_vec;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic [MAX_ENTRIES-1:0] sel_vec;
    logic                   found;
    logic                   hit;
    logic                   full;
    logic [FILL_W-1:0]      fill_m1;
    logic [IDX_W-1:0]       sel_idx;
    logic [IDX_W-1:0]       sel_rank;
    logic [FILL_W-1:0]      thresh;

    // Ranks of valid entries always form 0..fill-1, so the least recent
    // entry is the one whose rank equals fill-1.
    always_comb begin
        found   = 1'b0;
        full    = fill_count_reg >= eff_cap;
        fill_m1 = fill_count_reg - FILL_W'(1);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match_vec[i]  = valid_reg[i] && (entry_key_reg[i] == s_key);
            victim_vec[i] = valid_reg[i] && (FILL_W'(rank_reg[i]) == fill_m1);
            free_vec[i]   = !valid_reg[i] && !found;
            if (!valid_reg[i]) begin
                found = 1'b1;
            end
        end
        hit = |match_vec;
        if (hit) begin
            sel_vec = match_vec;
        end else if (full) begin
            sel_vec = victim_vec;
        end else begin
            sel_vec = free_vec;
        end
        sel_idx  = '0;
        sel_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (sel_vec[i]) begin
                sel_idx  = sel_idx | IDX_W'(i);
                sel_rank = sel_rank | rank_reg[i];
            end
        end
        // A fresh insert ages every valid entry, i.e. all ranks below fill.
        if (hit || full) begin
            thresh = FILL_W'(sel_rank);
        end else begin
            thresh = fill_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= s_kind;
            hit_reg    <= hit;
            insert_reg <= (s_kind == KIND_PUT) && !hit && !full;
            slot_reg   <= sel_idx;
            thresh_reg <= thresh;
            key_reg    <= s_key;
            value_reg  <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            fill_count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (cmd.update && (hit_reg || kind_reg == KIND_PUT)) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (valid_reg[i] && (FILL_W'(rank_reg[i]) < thresh_reg)) begin
                    rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                end
            end
            rank_reg[slot_reg] <= '0;
            if (insert_reg) begin
                valid_reg[slot_reg] <= 1'b1;
                fill_count_reg      <= fill_count_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            if (kind_reg == KIND_PUT) begin
                entry_key_reg[slot_reg]   <= key_reg;
                entry_value_reg[slot_reg] <= value_reg;
                m_read_value_reg          <= '0;
            end else if (hit_reg) begin
                m_read_value_reg <= entry_value_reg[slot_reg];
            end else begin
                m_read_value_reg <= READ_MISS;
            end
            m_hit_reg <= hit_reg;
        end
    end

    assign m_hit        = m_hit_reg;
    assign m_read_value = m_read_value_reg;

endmodule

### hw/rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// LRU key-value cache top level: APB capacity register, controller, datapath.
// A word is compared and captured when accepted in the idle state, then its
// result is registered in the update state; no new word is taken before that;
// the update waits while an earlier result is still held on the output.
// Reset (aresetn low, synchronous) empties the cache and sets capacity to 16.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.

module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic signed [KEY_W-1:0]  s_key,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_hit,
    output logic signed [DATA_W-1:0] m_read_value
);

    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);

    logic [CAP_W-1:0]  capacity_reg;
    logic [FILL_W-1:0] eff_cap;
    lkvc_cmd_t         cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == REG_CAPACITY_ADDR) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CAPACITY_ADDR) ? APB_DATA_W'(capacity_reg) : '0;

    // Zero acts as one entry; anything above the store size acts as full size.
    always_comb begin
        if (capacity_reg == '0) begin
            eff_cap = FILL_W'(1);
        end else if (int'(capacity_reg) > MAX_ENTRIES) begin
            eff_cap = FILL_W'(MAX_ENTRIES);
        end else begin
            eff_cap = FILL_W'(capacity_reg);
        end
    end

    lkvc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lkvc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_kind       (s_kind),
        .s_key        (s_key),
        .s_value      (s_value),
        .eff_cap      (eff_cap),
        .m_hit        (m_hit),
        .m_read_value (m_read_value)
    );

    a_one_word_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word was still in flight");

    a_miss_or_put_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_read_value == '0 || m_read_value == READ_MISS))
        else $error("miss result carries a stored value");

    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> ##1 m_valid)
        else $error("result not presented two cycles after accept");

endmodule
